// ===== hw/rtl/u8d_pkg.sv =====
// Shared constants and types of the UTF-8 stream decoder.
package u8d_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned CP_WIDTH    = 21;

   localparam logic [CP_WIDTH-1:0] REPLACEMENT_CP = 21'h00FFFD;

   // Byte tags, compared against the upper bits of a byte.
   localparam logic [1:0] CONT_TAG  = 2'b10;
   localparam logic [2:0] LEAD2_TAG = 3'b110;
   localparam logic [3:0] LEAD3_TAG = 4'b1110;
   localparam logic [4:0] LEAD4_TAG = 5'b11110;

   // One queued command: a single result, or a replacement followed by an end marker.
   typedef struct packed {
      logic [CP_WIDTH-1:0] code_point;
      logic                malformed;
      logic                at_end;
      logic                dual;
   } cmd_type;

   typedef struct packed {
      logic    empty;
      cmd_type head;
   } queue_status_type;

   typedef struct packed {
      logic [CP_WIDTH-1:0] code_point;
      logic                malformed;
      logic                at_end;
      logic                last;
   } result_type;

endpackage

// ===== hw/rtl/u8d_ifs.sv =====
// Channel interfaces of the UTF-8 stream decoder.
interface u8d_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       end_of_input;

   modport source (output valid, output byte_value, output end_of_input, input ready);
   modport sink (input valid, input byte_value, input end_of_input, output ready);
endinterface

interface u8d_rsp_if;
   logic        valid;
   logic        ready;
   logic [20:0] code_point;
   logic        malformed;
   logic        at_end;
   logic        last;

   modport source (output valid, output code_point, output malformed, output at_end,
                   output last, input ready);
   modport sink (input valid, input code_point, input malformed, input at_end,
                 input last, output ready);
endinterface

// ===== hw/rtl/u8d_front.sv =====
// Front end: accepts bytes, tracks the pending sequence and issues result commands.
module u8d_front (
   input  logic               clock,
   input  logic               reset,
   u8d_req_if.sink            req_bus,
   input  logic               queue_full,
   output logic               push,
   output u8d_pkg::cmd_type   push_cmd
);

   logic [1:0]                     bytes_pending_ff, bytes_pending_in;
   logic [u8d_pkg::CP_WIDTH-1:0]   partial_ff, partial_in;
   logic [u8d_pkg::CP_WIDTH-1:0]   shifted;
   logic                           accept;
   logic                           emit;
   logic [7:0]                     b;

   assign req_bus.ready = !queue_full;
   assign accept        = req_bus.valid && !queue_full;
   assign b             = req_bus.byte_value;
   assign shifted       = {partial_ff[u8d_pkg::CP_WIDTH-7:0], b[5:0]};

   always_comb begin
      bytes_pending_in = bytes_pending_ff;
      partial_in       = partial_ff;
      emit             = 1'b0;
      push_cmd         = '0;
      if (req_bus.end_of_input) begin
         emit             = 1'b1;
         push_cmd.at_end  = 1'b1;
         push_cmd.dual    = (bytes_pending_ff != 2'd0);
         bytes_pending_in = 2'd0;
         partial_in       = '0;
      end else if (bytes_pending_ff == 2'd0) begin
         if (b[7] == 1'b0) begin
            emit                = 1'b1;
            push_cmd.code_point = {13'd0, b};
         end else if (b[7:5] == u8d_pkg::LEAD2_TAG) begin
            bytes_pending_in = 2'd1;
            partial_in       = {16'd0, b[4:0]};
         end else if (b[7:4] == u8d_pkg::LEAD3_TAG) begin
            bytes_pending_in = 2'd2;
            partial_in       = {17'd0, b[3:0]};
         end else if (b[7:3] == u8d_pkg::LEAD4_TAG) begin
            bytes_pending_in = 2'd3;
            partial_in       = {18'd0, b[2:0]};
         end else begin
            emit                = 1'b1;
            push_cmd.code_point = u8d_pkg::REPLACEMENT_CP;
            push_cmd.malformed  = 1'b1;
         end
      end else if (b[7:6] != u8d_pkg::CONT_TAG) begin
         // A bad continuation byte is swallowed along with the pending sequence.
         emit                = 1'b1;
         push_cmd.code_point = u8d_pkg::REPLACEMENT_CP;
         push_cmd.malformed  = 1'b1;
         bytes_pending_in    = 2'd0;
         partial_in          = '0;
      end else begin
         bytes_pending_in = bytes_pending_ff - 2'd1;
         if (bytes_pending_ff == 2'd1) begin
            emit                = 1'b1;
            push_cmd.code_point = shifted;
            partial_in          = '0;
         end else begin
            partial_in = shifted;
         end
      end
   end

   assign push = accept && emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_pending_ff <= 2'd0;
         partial_ff       <= '0;
      end else if (accept) begin
         bytes_pending_ff <= bytes_pending_in;
         partial_ff       <= partial_in;
      end
   end

endmodule

// ===== hw/rtl/u8d_queue.sv =====
// Command queue between the decode front end and the result back end.
module u8d_queue #(
   parameter int unsigned QueueDepth = u8d_pkg::QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  u8d_pkg::cmd_type           push_cmd,
   input  logic                       pop,
   output logic                       full,
   output u8d_pkg::queue_status_type  status
);

   localparam int unsigned PtrWidth   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int unsigned CountWidth = $clog2(QueueDepth + 1);

   u8d_pkg::cmd_type        entry_ff [QueueDepth];
   logic [PtrWidth-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CountWidth-1:0]   count_ff, count_in;
   logic                    do_push, do_pop;

   assign full         = (count_ff == CountWidth'(QueueDepth));
   assign status.empty = (count_ff == '0);
   assign status.head  = entry_ff[rd_ptr_ff];
   assign do_push      = push && !full;
   assign do_pop       = pop && !status.empty;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CountWidth'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CountWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0
                                                                   : wr_ptr_ff + PtrWidth'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0
                                                                   : rd_ptr_ff + PtrWidth'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(QueueDepth))
      else $error("queue count exceeds depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + CountWidth'(1)))
      else $error("queue count did not grow on push");

   a_ptrs_match_when_empty: assert property (@(posedge clock) disable iff (reset)
      (status.empty || full) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");
`endif

endmodule

// ===== hw/rtl/u8d_back.sv =====
// Back end: expands queued commands into result beats held in an output register.
module u8d_back (
   input  logic                       clock,
   input  logic                       reset,
   input  u8d_pkg::queue_status_type  status,
   output logic                       pop,
   u8d_rsp_if.source                  rsp_bus
);

   logic                  out_valid_ff, out_valid_in;
   u8d_pkg::result_type   out_ff, out_in;
   logic                  phase_ff, phase_in;
   logic                  load;

   assign load = !out_valid_ff || rsp_bus.ready;

   always_comb begin
      pop          = 1'b0;
      phase_in     = phase_ff;
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      out_in       = out_ff;
      if (load && !status.empty) begin
         out_valid_in = 1'b1;
         if (status.head.dual && !phase_ff) begin
            // Truncated sequence at end of file: replacement beat first.
            out_in.code_point = u8d_pkg::REPLACEMENT_CP;
            out_in.malformed  = 1'b1;
            out_in.at_end     = 1'b0;
            out_in.last       = 1'b0;
            phase_in          = 1'b1;
         end else begin
            out_in.code_point = status.head.code_point;
            out_in.malformed  = status.head.malformed;
            out_in.at_end     = status.head.at_end;
            out_in.last       = 1'b1;
            if (status.head.dual) begin
               out_in.code_point = '0;
               out_in.malformed  = 1'b0;
            end
            phase_in = 1'b0;
            pop      = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.code_point = out_ff.code_point;
   assign rsp_bus.malformed  = out_ff.malformed;
   assign rsp_bus.at_end     = out_ff.at_end;
   assign rsp_bus.last       = out_ff.last;

`ifndef SYNTHESIS
   a_phase_has_dual: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (!status.empty && status.head.dual))
      else $error("second half pending without a dual command at the head");

   a_end_is_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.at_end) |-> (out_ff.code_point == '0 && !out_ff.malformed))
      else $error("end-of-file beat carries a code point");

   a_not_last_is_replacement: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff.last) |-> (out_ff.malformed && phase_ff))
      else $error("non-last beat is not the replacement of a truncated sequence");
`endif

endmodule

// ===== hw/rtl/utf8_stream_decoder.sv =====
// UTF-8 stream decoder: one byte (or end-of-file marker) in, code points out.
//
// req_bus carries one byte per beat, or an end-of-file marker with the byte ignored.
// rsp_bus carries one code point per beat with malformed, at_end and last flags.
// A complete sequence gives one beat; bytes inside a sequence give none. A bad lead
// byte or a bad continuation byte gives U+FFFD with malformed set. End of file gives
// an at_end beat, preceded by U+FFFD when a sequence was left unfinished.
//
// Throughput is one input byte per cycle while the queue is not full. Results leave one
// per cycle from the output register while the receiver is ready; an unfinished sequence
// at end of file gives a U+FFFD beat before its at_end beat. The command of an accepted
// byte is written into the queue at the accepting edge and is loaded from the queue into
// the output register once it is empty or being taken. The front end decodes and updates
// the sequence state in the accept cycle and pushes a command into a queue of QueueDepth
// entries. req_bus.ready drops only when that queue is full, so a stalled receiver backs
// up into the queue before it stops the sender.
// Reset (synchronous, active high) clears the pending sequence, the queue and the
// output register; no item is lost or invented across a stall.
module utf8_stream_decoder #(
   parameter int unsigned QueueDepth = u8d_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   u8d_req_if.sink     req_bus,
   u8d_rsp_if.source   rsp_bus
);

   logic                        push;
   logic                        pop;
   logic                        queue_full;
   u8d_pkg::cmd_type            push_cmd;
   u8d_pkg::queue_status_type   status;

   u8d_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   u8d_queue #(
      .QueueDepth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .full     (queue_full),
      .status   (status)
   );

   u8d_back u_back (
      .clock   (clock),
      .reset   (reset),
      .status  (status),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

endmodule

// ===== tb/utf8_stream_decoder_checker.sv =====
// Checker of the UTF-8 stream decoder: predicts result beats from input beats and compares them.
module utf8_stream_decoder_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_byte_value,
   input  logic        req_end_of_input,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [20:0] rsp_code_point,
   input  logic        rsp_malformed,
   input  logic        rsp_at_end,
   input  logic        rsp_last,
   output int          fail_count,
   output int          outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [1:0]                   cont_left;
   logic [u8d_pkg::CP_WIDTH-1:0] cp_accum;
   u8d_pkg::result_type          decoded_q[$];

   task automatic add_decoded(input logic [u8d_pkg::CP_WIDTH-1:0] cp, input logic bad,
                              input logic eof_flag, input logic last_flag);
      u8d_pkg::result_type r;
      r.code_point = cp;
      r.malformed  = bad;
      r.at_end     = eof_flag;
      r.last       = last_flag;
      decoded_q.push_back(r);
   endtask

   task automatic decode_byte(input logic [7:0] b, input logic eof);
      if (eof) begin
         if (cont_left != 2'd0) begin
            add_decoded(u8d_pkg::REPLACEMENT_CP, 1'b1, 1'b0, 1'b0);
         end
         add_decoded('0, 1'b0, 1'b1, 1'b1);
         cont_left = 2'd0;
         cp_accum  = '0;
      end else if (cont_left == 2'd0) begin
         if (!b[7]) begin
            add_decoded({13'b0, b}, 1'b0, 1'b0, 1'b1);
         end else if (b[7:5] == u8d_pkg::LEAD2_TAG) begin
            cont_left = 2'd1;
            cp_accum  = {16'b0, b[4:0]};
         end else if (b[7:4] == u8d_pkg::LEAD3_TAG) begin
            cont_left = 2'd2;
            cp_accum  = {17'b0, b[3:0]};
         end else if (b[7:3] == u8d_pkg::LEAD4_TAG) begin
            cont_left = 2'd3;
            cp_accum  = {18'b0, b[2:0]};
         end else begin
            add_decoded(u8d_pkg::REPLACEMENT_CP, 1'b1, 1'b0, 1'b1);
         end
      end else if (b[7:6] != u8d_pkg::CONT_TAG) begin
         // The offending byte is swallowed; it never starts a new sequence.
         cont_left = 2'd0;
         cp_accum  = '0;
         add_decoded(u8d_pkg::REPLACEMENT_CP, 1'b1, 1'b0, 1'b1);
      end else begin
         cp_accum  = {cp_accum[u8d_pkg::CP_WIDTH-7:0], b[5:0]};
         cont_left = cont_left - 2'd1;
         if (cont_left == 2'd0) begin
            add_decoded(cp_accum, 1'b0, 1'b0, 1'b1);
            cp_accum = '0;
         end
      end
   endtask

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endtask

   // Result beats are handled before input beats: a result never comes from a byte
   // accepted at the same edge.
   always @(posedge clock) begin
      u8d_pkg::result_type want;
      if (reset) begin
         cont_left = 2'd0;
         cp_accum  = '0;
         decoded_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (decoded_q.size() == 0) begin
               $error("result beat with nothing expected: code_point %0h", rsp_code_point);
               fail_count++;
            end else begin
               want = decoded_q.pop_front();
               compare_field("code_point", 32'(want.code_point), 32'(rsp_code_point));
               compare_field("malformed", 32'(want.malformed), 32'(rsp_malformed));
               compare_field("at_end", 32'(want.at_end), 32'(rsp_at_end));
               compare_field("last", 32'(want.last), 32'(rsp_last));
            end
         end
         if (req_valid && req_ready) begin
            decode_byte(req_byte_value, req_end_of_input);
         end
      end
      outstanding = decoded_q.size();
   end

endmodule

// ===== tb/utf8_stream_decoder_tb.sv =====
// Top of the UTF-8 stream decoder testbench: clock, reset, byte stimulus and verdict.
module utf8_stream_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_BYTES = 1750;
   localparam int IDLE_LIMIT   = 5000;

   logic clock;
   logic reset;
   logic steady;
   int   fail_count;
   int   outstanding;
   int   bytes_sent;
   int   idle_cycles;

   u8d_req_if req_bus ();
   u8d_rsp_if rsp_bus ();

   utf8_stream_decoder dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   utf8_stream_decoder_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_bus.valid),
      .req_ready        (req_bus.ready),
      .req_byte_value   (req_bus.byte_value),
      .req_end_of_input (req_bus.end_of_input),
      .rsp_valid        (rsp_bus.valid),
      .rsp_ready        (rsp_bus.ready),
      .rsp_code_point   (rsp_bus.code_point),
      .rsp_malformed    (rsp_bus.malformed),
      .rsp_at_end       (rsp_bus.at_end),
      .rsp_last         (rsp_bus.last),
      .fail_count       (fail_count),
      .outstanding      (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Mostly no pause, often a short one, now and then a long one.
   function automatic int pick_pause();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic eof);
      int pause;
      pause = pick_pause();
      if (pause > 0) begin
         req_bus.valid <= 1'b0;
         repeat (pause) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.byte_value   <= b;
      req_bus.end_of_input <= eof;
      do @(posedge clock); while (!req_bus.ready);
      bytes_sent++;
   endtask

   task automatic send_text(input logic [7:0] b);
      send_byte(b, 1'b0);
   endtask

   task automatic send_eof();
      send_byte(8'($urandom), 1'b1);
   endtask

   function automatic logic [7:0] rand_cont();
      return 8'h80 | 8'($urandom_range(0, 63));
   endfunction

   function automatic logic [7:0] rand_lead(input int len);
      case (len)
         2: return 8'hC0 | 8'($urandom_range(0, 31));
         3: return 8'hE0 | 8'($urandom_range(0, 15));
         default: return 8'hF0 | 8'($urandom_range(0, 7));
      endcase
   endfunction

   task automatic send_directed();
      send_text(8'h00);
      send_text(8'h7F);
      send_text(8'hC3); send_text(8'hA9);
      send_text(8'hE2); send_text(8'h82); send_text(8'hAC);
      // Largest four-byte value: the lead's top value bit lands in bit 20.
      send_text(8'hF7); send_text(8'hBF); send_text(8'hBF); send_text(8'hBF);
      send_text(8'h80);
      send_text(8'hF8);
      send_text(8'hFF);
      send_text(8'hC3); send_text(8'h41);
      send_text(8'hE2); send_text(8'hC3);
      send_eof();
      send_eof();
      send_text(8'hF0); send_text(8'h90);
      send_eof();
   endtask

   task automatic send_random_unit();
      int kind;
      int len;
      int cut;
      logic [7:0] b;
      kind = $urandom_range(0, 99);
      if (kind < 28) begin
         send_text(8'($urandom_range(0, 127)));
      end else if (kind < 75) begin
         len = $urandom_range(2, 4);
         send_text(rand_lead(len));
         repeat (len - 1) send_text(rand_cont());
      end else if (kind < 80) begin
         send_eof();
      end else if (kind < 90) begin
         // Sequence cut short, then followed by end of file, a byte that is not a continuation, or a random byte.
         len = $urandom_range(2, 4);
         cut = $urandom_range(1, len - 1);
         send_text(rand_lead(len));
         repeat (cut - 1) send_text(rand_cont());
         case ($urandom_range(0, 2))
            0: send_eof();
            1: begin
               b = 8'($urandom);
               if (b[7:6] == 2'b10) b[6] = 1'b1;
               send_text(b);
            end
            default: send_text(8'($urandom));
         endcase
      end else begin
         send_text(8'($urandom));
      end
   endtask

   initial begin
      bit paused;
      paused               = 1'b0;
      steady               = 1'b0;
      bytes_sent           = 0;
      reset               <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.byte_value   <= '0;
      req_bus.end_of_input <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_directed();
      bytes_sent = 0;
      while (bytes_sent < RANDOM_BYTES) begin
         steady = (bytes_sent >= 400 && bytes_sent < 550);
         if (!paused && bytes_sent >= 900) begin
            // Let the decoder drain completely before going on.
            paused = 1'b1;
            req_bus.valid <= 1'b0;
            do @(posedge clock); while (outstanding != 0);
         end
         send_random_unit();
      end
      steady = 1'b0;
      req_bus.valid <= 1'b0;

      do @(posedge clock); while (outstanding != 0);
      repeat (8) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Receiver: ready runs of random length broken by stalls.
   initial begin
      int run;
      int stall;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         run = $urandom_range(1, 24);
         rsp_bus.ready <= 1'b1;
         repeat (run) @(posedge clock);
         stall = pick_pause();
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
